// ----- rtl/mfb_pkg.sv -----
package mfb_pkg;

	typedef struct packed {
		logic       first;
		logic       auto_id;
		logic [7:0] msg_id;
		logic [7:0] msg_type;
		logic [7:0] payload_len;
		logic [7:0] data_byte;
	} msg_in_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       frame_end;
	} frame_out_t;

	localparam int unsigned CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = 1'b1;

	localparam logic [7:0] START_BYTE_RST = 8'd2;
	localparam logic [7:0] END_BYTE_RST   = 8'd3;

	// Longest burst caused by one item: a whole frame with a single payload byte.
	localparam int unsigned MAX_BYTES = 7;
	localparam int unsigned CNT_W     = 3;

endpackage

// ----- rtl/message_frame_builder_sum8_top.sv -----
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+------------------------------------------
// in       | input     | in_valid / in_ready    | in_data  (mfb_pkg::msg_in_t)
// out      | output    | out_valid / out_ready  | out_data (mfb_pkg::frame_out_t)
// cfg      | input     | cfg_valid / cfg_ready  | cfg_index, cfg_data (delimiter registers)
//
// Each input transfer is turned into its full burst of frame bytes and loaded
// into a seven-entry output shift register, which then drains one byte per output transfer.
// A payload item inside a frame gives one byte, or three when it closes the frame, so
// payload items that do not close it stream at one item per cycle while out_ready stays
// high; a header item gives five to seven bytes, and each burst holds the input back.
// A new item is taken in the same cycle as the last byte of the previous burst leaves.
// Reset (arst_n low, asynchronous) clears the frame state, the id counter and the burst
// count, and restores the delimiters to 2 and 3. The config port is always ready.
module message_frame_builder_sum8_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  mfb_pkg::msg_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output mfb_pkg::frame_out_t           out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mfb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);
	import mfb_pkg::*;

	// Delimiter registers.
	logic [7:0] start_byte_q;
	logic [7:0] end_byte_q;

	// Frame state, updated at every input transfer.
	logic [7:0] running_sum_q;
	logic [7:0] bytes_left_q;
	logic       in_frame_q;
	logic [7:0] id_counter_q;

	// Output burst: slot 0 is the byte on offer, count is the number of bytes left.
	frame_out_t             slots_s1 [MAX_BYTES];
	logic [CNT_W-1:0]       cnt_s1;

	logic in_xfer;
	logic out_xfer;

	frame_out_t       load_slots [MAX_BYTES];
	logic [CNT_W-1:0] load_cnt;
	logic [7:0]       nxt_sum;
	logic [7:0]       nxt_left;
	logic             nxt_in_frame;
	logic [7:0]       nxt_id_counter;

	logic [7:0] id_val;
	logic [7:0] hdr_sum;
	logic [7:0] hdr_sum_data;
	logic [7:0] run_sum_data;

	assign cfg_ready = 1'b1;
	assign out_valid = (cnt_s1 != '0);
	assign out_data  = slots_s1[0];
	assign out_xfer  = out_valid && out_ready;

	// Take a new item when the burst register is empty or its last byte leaves now.
	assign in_ready = (cnt_s1 == '0) || ((cnt_s1 == CNT_W'(1)) && out_ready);
	assign in_xfer  = in_valid && in_ready;

	assign id_val       = in_data.auto_id ? (id_counter_q + 8'd1) : in_data.msg_id;
	assign hdr_sum      = id_val + in_data.msg_type + in_data.payload_len;
	assign hdr_sum_data = hdr_sum + in_data.data_byte;
	assign run_sum_data = running_sum_q + in_data.data_byte;

	// Build the whole burst for the incoming item and the frame state it leaves behind.
	always_comb begin
		for (int i = 0; i < MAX_BYTES; i++) begin
			load_slots[i] = '{frame_byte: 8'd0, frame_end: 1'b0};
		end
		load_cnt       = '0;
		nxt_sum        = running_sum_q;
		nxt_left       = bytes_left_q;
		nxt_in_frame   = in_frame_q;
		nxt_id_counter = id_counter_q;

		if (in_data.first) begin
			if (in_data.auto_id) begin
				nxt_id_counter = id_val;
			end
			load_slots[0] = '{frame_byte: start_byte_q,        frame_end: 1'b0};
			load_slots[1] = '{frame_byte: id_val,              frame_end: 1'b0};
			load_slots[2] = '{frame_byte: in_data.msg_type,    frame_end: 1'b0};
			load_slots[3] = '{frame_byte: in_data.payload_len, frame_end: 1'b0};
			if (in_data.payload_len == 8'd0) begin
				// Empty payload: the frame closes at once and the data byte is dropped.
				load_slots[4] = '{frame_byte: hdr_sum,    frame_end: 1'b0};
				load_slots[5] = '{frame_byte: end_byte_q, frame_end: 1'b1};
				load_cnt      = CNT_W'(6);
				nxt_sum       = 8'd0;
				nxt_left      = 8'd0;
				nxt_in_frame  = 1'b0;
			end else if (in_data.payload_len == 8'd1) begin
				// Single payload byte: the whole frame comes from this one item.
				load_slots[4] = '{frame_byte: in_data.data_byte, frame_end: 1'b0};
				load_slots[5] = '{frame_byte: hdr_sum_data,      frame_end: 1'b0};
				load_slots[6] = '{frame_byte: end_byte_q,        frame_end: 1'b1};
				load_cnt      = CNT_W'(7);
				nxt_sum       = 8'd0;
				nxt_left      = 8'd0;
				nxt_in_frame  = 1'b0;
			end else begin
				load_slots[4] = '{frame_byte: in_data.data_byte, frame_end: 1'b0};
				load_cnt      = CNT_W'(5);
				nxt_sum       = hdr_sum_data;
				nxt_left      = in_data.payload_len - 8'd1;
				nxt_in_frame  = 1'b1;
			end
		end else if (in_frame_q) begin
			load_slots[0] = '{frame_byte: in_data.data_byte, frame_end: 1'b0};
			if (bytes_left_q == 8'd1) begin
				// Last payload byte closes the frame with the checksum and end delimiter.
				load_slots[1] = '{frame_byte: run_sum_data, frame_end: 1'b0};
				load_slots[2] = '{frame_byte: end_byte_q,   frame_end: 1'b1};
				load_cnt      = CNT_W'(3);
				nxt_sum       = 8'd0;
				nxt_left      = 8'd0;
				nxt_in_frame  = 1'b0;
			end else begin
				load_cnt = CNT_W'(1);
				nxt_sum  = run_sum_data;
				nxt_left = bytes_left_q - 8'd1;
			end
		end
		// An item outside a frame is consumed and leaves no bytes.
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q <= START_BYTE_RST;
			end_byte_q   <= END_BYTE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_START_BYTE: start_byte_q <= cfg_data;
				REG_END_BYTE:   end_byte_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= 8'd0;
			bytes_left_q  <= 8'd0;
			in_frame_q    <= 1'b0;
			id_counter_q  <= 8'd0;
		end else if (in_xfer) begin
			running_sum_q <= nxt_sum;
			bytes_left_q  <= nxt_left;
			in_frame_q    <= nxt_in_frame;
			id_counter_q  <= nxt_id_counter;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= '0;
		end else if (in_xfer) begin
			cnt_s1 <= load_cnt;
		end else if (out_xfer) begin
			cnt_s1 <= cnt_s1 - CNT_W'(1);
		end
	end

	// Burst bytes carry no reset; only the count says which slots are live.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			slots_s1 <= load_slots;
		end else if (out_xfer) begin
			for (int i = 0; i < MAX_BYTES - 1; i++) begin
				slots_s1[i] <= slots_s1[i+1];
			end
		end
	end

endmodule
